// ===== design/bilinear_image_resampler_unit_assert.svh =====
// Assertion macros for the bilinear image resampler.
// Standalone header, no dependencies; define ASSERT_OFF to drop the checks.
`ifndef BILINEAR_IMAGE_RESAMPLER_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESAMPLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BIR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);
`define BIR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);
`else
`define BIR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define BIR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/bir_pkg.sv =====
// Shared types and constants of the bilinear image resampler.
// No dependencies; used by bir_pixel_store and bilinear_image_resampler_unit.
package bir_pkg;

  localparam int MAX_HEIGHT_DEF    = 512;
  localparam int MAX_WIDTH_DEF     = 512;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SIZE_W  = 10;
  localparam int STEP_W  = 26;
  localparam int COORD_W = 9;
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int OUT_W   = 16;
  localparam int CIDX_W  = 2;

  localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1);
  localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1);
  localparam logic [STEP_W-1:0] STEP_RST   = STEP_W'(65536);

  typedef enum logic [CIDX_W-1:0] {
    REG_HEIGHT  = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_VSTEP   = 2'd2,
    REG_HSTEP   = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

  function automatic logic [CHAN_W-1:0] chan_of(input logic [PIX_W-1:0] px, input chan_t c);
    logic [CHAN_W-1:0] v;
    v = px[CHAN_W-1:0];
    unique case (c)
      CH_RED:   v = px[3*CHAN_W-1:2*CHAN_W];
      CH_GREEN: v = px[2*CHAN_W-1:CHAN_W];
      CH_BLUE:  v = px[CHAN_W-1:0];
      default:  v = px[CHAN_W-1:0];
    endcase
    return v;
  endfunction

endpackage

// ===== design/bir_pixel_store.sv =====
// Single-port pixel store with registered read data.
// Depends on bir_pkg (store_ctl_t, PIX_W).
module bir_pixel_store #(
  parameter int DEPTH = bir_pkg::MAX_HEIGHT_DEF * bir_pkg::MAX_WIDTH_DEF,
  parameter int AW    = 18
) (
  input  logic                         clk,
  input  bir_pkg::store_ctl_t          ctl,
  input  logic [AW-1:0]                addr,
  input  logic [bir_pkg::PIX_W-1:0]    wdata,
  output logic [bir_pkg::PIX_W-1:0]    rdata
);

  logic [bir_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bir_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bilinear_image_resampler_unit.sv =====
// Bilinear image resampler top level: config registers, sequencer, shared MAC.
// Depends on bir_pkg, bir_pixel_store and bilinear_image_resampler_unit_assert.svh.
//
//  channel | ports                                        | handshake
//  in      | in_cmd in_row in_col in_red_in/green/blue_in | start & !busy
//  out     | out_red_out out_green_out out_blue_out       | out_valid strobe
//  cfg     | cfg_index cfg_data                           | cfg_valid & cfg_ready
//
// Load: written at accept if in range; busy stays low, next word may follow at once.
// Sample: busy through two coordinate products, four reads from the single-port
// pixel store, then 18 passes through the one multiply-accumulate unit (6 per channel).
// out_valid pulses for one cycle as busy falls; the receiver cannot stall.
// rst_n is synchronous; the pixel store has no reset and is valid once written.
`include "bilinear_image_resampler_unit_assert.svh"
module bilinear_image_resampler_unit #(
  parameter int MAX_HEIGHT    = bir_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH     = bir_pkg::MAX_WIDTH_DEF,
  parameter int FRACTION_BITS = bir_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [bir_pkg::COORD_W-1:0]   in_row,
  input  logic [bir_pkg::COORD_W-1:0]   in_col,
  input  logic [bir_pkg::CHAN_W-1:0]    in_red_in,
  input  logic [bir_pkg::CHAN_W-1:0]    in_green_in,
  input  logic [bir_pkg::CHAN_W-1:0]    in_blue_in,
  output logic                          out_valid,
  output logic [bir_pkg::OUT_W-1:0]     out_red_out,
  output logic [bir_pkg::OUT_W-1:0]     out_green_out,
  output logic [bir_pkg::OUT_W-1:0]     out_blue_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bir_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [bir_pkg::STEP_W-1:0]    cfg_data
);

  localparam int FB    = FRACTION_BITS;
  localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int MA    = FB + bir_pkg::CHAN_W;
  localparam int MB    = bir_pkg::STEP_W;
  localparam int PW    = MA + MB;
  localparam int CPW   = bir_pkg::COORD_W + bir_pkg::STEP_W;
  localparam int IPW   = CPW - FB;
  localparam int OSH   = 2 * FB - bir_pkg::CHAN_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MULY  = 6'b000010,
    S_MULX  = 6'b000100,
    S_MAPX  = 6'b001000,
    S_READ  = 6'b010000,
    S_BLEND = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    B_TOP0 = 3'd0,
    B_TOP1 = 3'd1,
    B_BOT0 = 3'd2,
    B_BOT1 = 3'd3,
    B_MIX0 = 3'd4,
    B_MIX1 = 3'd5
  } bstep_t;

  state_t state_r, state_nxt;
  bstep_t bstep_r;
  bir_pkg::chan_t chan_r;
  logic [2:0] rcnt_r;
  logic [2:0] rprev;

  logic [bir_pkg::SIZE_W-1:0] hgt_r, wid_r;
  logic [bir_pkg::STEP_W-1:0] vstep_r, hstep_r;

  logic [bir_pkg::COORD_W-1:0] row_r, col_r;
  logic [YW-1:0] y0_r, y1_r, y_lo, h_last;
  logic [XW-1:0] x0_r, x1_r, x_lo, w_last;
  logic [FB-1:0] fy_r, fx_r;
  logic [IPW-1:0] ip;
  logic [PW-1:0] acc_r, prod, sum;
  logic [MA-1:0] top_r, bot_r;
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic add_en;
  logic [bir_pkg::PIX_W-1:0] pix_r [4];
  logic [bir_pkg::OUT_W-1:0] red_r, green_r, blue_r;
  logic out_valid_r;

  logic accept, load_ok;
  bir_pkg::store_ctl_t st_ctl;
  logic [AW-1:0] st_addr;
  logic [bir_pkg::PIX_W-1:0] st_rdata;
  logic [YW-1:0] rd_y;
  logic [XW-1:0] rd_x;
  logic [MB-1:0] one_m_fx, one_m_fy;
  logic [bir_pkg::CHAN_W-1:0] p00, p01, p10, p11;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_ok   = (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hgt_r   <= bir_pkg::HEIGHT_RST;
      wid_r   <= bir_pkg::WIDTH_RST;
      vstep_r <= bir_pkg::STEP_RST;
      hstep_r <= bir_pkg::STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bir_pkg::reg_idx_t'(cfg_index))
        bir_pkg::REG_HEIGHT: hgt_r   <= cfg_data[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_WIDTH:  wid_r   <= cfg_data[bir_pkg::SIZE_W-1:0];
        bir_pkg::REG_VSTEP:  vstep_r <= cfg_data;
        bir_pkg::REG_HSTEP:  hstep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // last valid row / column
  assign h_last = (hgt_r == '0) ? '0 :
                  (32'(hgt_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1) : YW'(hgt_r - 1'b1);
  assign w_last = (wid_r == '0) ? '0 :
                  (32'(wid_r) > MAX_WIDTH) ? XW'(MAX_WIDTH - 1) : XW'(wid_r - 1'b1);

  assign ip   = acc_r[CPW-1:FB];
  assign y_lo = (32'(ip) > 32'(h_last)) ? h_last : YW'(ip);
  assign x_lo = (32'(ip) > 32'(w_last)) ? w_last : XW'(ip);

  // shared multiply-accumulate
  assign one_m_fx = MB'({1'b1, {FB{1'b0}}}) - MB'(fx_r);
  assign one_m_fy = MB'({1'b1, {FB{1'b0}}}) - MB'(fy_r);
  assign p00 = bir_pkg::chan_of(pix_r[0], chan_r);
  assign p01 = bir_pkg::chan_of(pix_r[1], chan_r);
  assign p10 = bir_pkg::chan_of(pix_r[2], chan_r);
  assign p11 = bir_pkg::chan_of(pix_r[3], chan_r);

  always_comb begin
    mul_a  = MA'(row_r);
    mul_b  = vstep_r;
    add_en = 1'b0;
    unique case (state_r)
      S_MULX: begin
        mul_a = MA'(col_r);
        mul_b = hstep_r;
      end
      S_BLEND: begin
        unique case (bstep_r)
          B_TOP0: begin mul_a = MA'(p00); mul_b = one_m_fx; end
          B_TOP1: begin mul_a = MA'(p01); mul_b = MB'(fx_r); add_en = 1'b1; end
          B_BOT0: begin mul_a = MA'(p10); mul_b = one_m_fx; end
          B_BOT1: begin mul_a = MA'(p11); mul_b = MB'(fx_r); add_en = 1'b1; end
          B_MIX0: begin mul_a = top_r;    mul_b = one_m_fy; end
          B_MIX1: begin mul_a = bot_r;    mul_b = MB'(fy_r); add_en = 1'b1; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);
  assign sum  = add_en ? (acc_r + prod) : prod;

  // store port
  assign rprev = rcnt_r - 3'd1;
  assign rd_y  = rcnt_r[1] ? y1_r : y0_r;
  assign rd_x  = rcnt_r[0] ? x1_r : x0_r;

  always_comb begin
    st_ctl.wr = accept && (bir_pkg::cmd_t'(in_cmd) == bir_pkg::CMD_LOAD) && load_ok;
    st_ctl.rd = (state_r == S_READ) && !rcnt_r[2];
    if (state_r == S_READ) begin
      st_addr = AW'(32'(rd_y) * MAX_WIDTH + 32'(rd_x));
    end else begin
      st_addr = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));
    end
  end

  bir_pixel_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .addr  (st_addr),
    .wdata ({in_red_in, in_green_in, in_blue_in}),
    .rdata (st_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && (bir_pkg::cmd_t'(in_cmd) == bir_pkg::CMD_SAMPLE)) begin
                 state_nxt = S_MULY;
               end
      S_MULY:  state_nxt = S_MULX;
      S_MULX:  state_nxt = S_MAPX;
      S_MAPX:  state_nxt = S_READ;
      S_READ:  if (rcnt_r[2]) begin
                 state_nxt = S_BLEND;
               end
      S_BLEND: if ((bstep_r == B_MIX1) && (chan_r == bir_pkg::CH_BLUE)) begin
                 state_nxt = S_IDLE;
               end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bstep_r     <= B_TOP0;
      chan_r      <= bir_pkg::CH_RED;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      if (state_r == S_MAPX) begin
        rcnt_r <= '0;
      end else if (state_r == S_READ) begin
        rcnt_r <= rcnt_r + 3'd1;
      end
      if (state_r == S_READ) begin
        bstep_r <= B_TOP0;
        chan_r  <= bir_pkg::CH_RED;
      end else if (state_r == S_BLEND) begin
        if (bstep_r == B_MIX1) begin
          bstep_r <= B_TOP0;
          chan_r  <= bir_pkg::chan_t'(chan_r + 2'd1);
          if (chan_r == bir_pkg::CH_BLUE) begin
            out_valid_r <= 1'b1;
          end
        end else begin
          bstep_r <= bstep_t'(bstep_r + 3'd1);
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      row_r <= in_row;
      col_r <= in_col;
    end
    if ((state_r == S_MULY) || (state_r == S_MULX) || (state_r == S_BLEND)) begin
      acc_r <= sum;
    end
    if (state_r == S_MULX) begin
      y0_r <= y_lo;
      y1_r <= (y_lo == h_last) ? h_last : y_lo + 1'b1;
      fy_r <= acc_r[FB-1:0];
    end
    if (state_r == S_MAPX) begin
      x0_r <= x_lo;
      x1_r <= (x_lo == w_last) ? w_last : x_lo + 1'b1;
      fx_r <= acc_r[FB-1:0];
    end
    if ((state_r == S_READ) && (rcnt_r != '0)) begin
      pix_r[rprev[1:0]] <= st_rdata;
    end
    if (state_r == S_BLEND) begin
      if (bstep_r == B_TOP1) begin
        top_r <= sum[MA-1:0];
      end
      if (bstep_r == B_BOT1) begin
        bot_r <= sum[MA-1:0];
      end
      if (bstep_r == B_MIX1) begin
        unique case (chan_r)
          bir_pkg::CH_RED:   red_r   <= sum[OSH +: bir_pkg::OUT_W];
          bir_pkg::CH_GREEN: green_r <= sum[OSH +: bir_pkg::OUT_W];
          default:           blue_r  <= sum[OSH +: bir_pkg::OUT_W];
        endcase
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

  `BIR_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")
  `BIR_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy, "result strobed while busy")
  `BIR_ASSERT_NXT(a_sample_busy, clk, rst_n, accept && (in_cmd == bir_pkg::CMD_SAMPLE), busy, "sample accepted but not busy")
  `BIR_ASSERT_IMP(a_nbr_order, clk, rst_n, state_r == S_BLEND, ((y1_r == y0_r) || (32'(y1_r) == 32'(y0_r) + 1)) && ((x1_r == x0_r) || (32'(x1_r) == 32'(x0_r) + 1)), "neighbor indexes out of order")
  `BIR_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, (out_red_out <= 16'hFF00) && (out_green_out <= 16'hFF00) && (out_blue_out <= 16'hFF00), "result above full scale")

endmodule
